[sv/cpp_pkg.sv]
// Package with the shared widths, types and saturation helpers of the particle push pipeline.
package cpp_pkg;

    localparam int VW   = 32;   // velocity and field, Q4.28
    localparam int PW   = 48;   // position, Q20.28
    localparam int FRAC = 28;
    localparam int AW   = 37;   // rounded cross product term
    localparam int SW   = 38;   // velocity or acceleration times step
    localparam int DTW  = 29;   // step size, unsigned Q1.28
    localparam int IDXW = 3;    // configuration register index
    localparam int NS   = 13;   // pipeline stages

    localparam logic [IDXW-1:0] CFG_FIELD_X = 3'd0;
    localparam logic [IDXW-1:0] CFG_FIELD_Y = 3'd1;
    localparam logic [IDXW-1:0] CFG_FIELD_Z = 3'd2;
    localparam logic [IDXW-1:0] CFG_STEP    = 3'd3;
    localparam logic [IDXW-1:0] CFG_MODE    = 3'd4;

    localparam logic signed [VW-1:0] FIELD_Z_RESET = 32'sd268435456;
    localparam logic [DTW-1:0]       STEP_RESET    = 29'd2684355;

    typedef logic signed [VW-1:0] t_vel3 [3];
    typedef logic signed [PW-1:0] t_pos3 [3];
    typedef logic signed [AW-1:0] t_acc3 [3];
    typedef logic signed [SW-1:0] t_scl3 [3];

    typedef struct packed {
        logic [NS-1:0] en;      // stage k loads in this cycle
        logic [NS-1:0] valid;   // stage k holds a word
    } t_pipe_ctrl;

    function automatic logic signed [VW-1:0] sat_vel(input logic signed [VW+6:0] x);
        if (x[VW+6:VW-1] != {8{x[VW+6]}}) begin
            return x[VW+6] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
        return x[VW-1:0];
    endfunction

    function automatic logic vel_ovf(input logic signed [VW+6:0] x);
        return x[VW+6:VW-1] != {8{x[VW+6]}};
    endfunction

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW:0] x);
        if (x[PW] != x[PW-1]) begin
            return x[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end
        return x[PW-1:0];
    endfunction

    function automatic logic pos_ovf(input logic signed [PW:0] x);
        return x[PW] != x[PW-1];
    endfunction

endpackage

[sv/cpp_pipe_ctrl.sv]
// Valid chain and per-stage load enables of the push pipeline.
module cpp_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output cpp_pkg::t_pipe_ctrl o_ctrl
);

    logic [cpp_pkg::NS-1:0] r_valid;
    logic [cpp_pkg::NS-1:0] n_valid;
    logic [cpp_pkg::NS-1:0] w_en;

    // A stage may load when the sink takes a word or any stage from it on is empty.
    always_comb begin
        for (int k = 0; k < cpp_pkg::NS; k++) begin
            w_en[k] = i_out_ready || ((~r_valid & ({cpp_pkg::NS{1'b1}} << k)) != '0);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_en[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k < cpp_pkg::NS; k++) begin
            if (w_en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctrl.en    = w_en;
    assign o_ctrl.valid = r_valid;

endmodule

[sv/cpp_cross.sv]
// Two-stage cross product v x B with round half up to Q.28.
module cpp_cross (
    input  logic          i_clk,
    input  logic [1:0]    i_en,
    input  cpp_pkg::t_vel3 i_vel,
    input  cpp_pkg::t_vel3 i_field,
    output cpp_pkg::t_acc3 o_acc
);

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    logic signed [2*cpp_pkg::VW-1:0] r_pa [3];
    logic signed [2*cpp_pkg::VW-1:0] r_pb [3];
    logic signed [2*cpp_pkg::VW:0]   w_diff [3];
    cpp_pkg::t_acc3                  r_acc;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= 64'(i_vel[NXT[i]]) * 64'(i_field[PRV[i]]);
                r_pb[i] <= 64'(i_vel[PRV[i]]) * 64'(i_field[NXT[i]]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = 65'(r_pa[i]) - 65'(r_pb[i]) + (65'sd1 <<< (cpp_pkg::FRAC - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= w_diff[i][cpp_pkg::FRAC+cpp_pkg::AW-1:cpp_pkg::FRAC];
            end
        end
    end

    assign o_acc = r_acc;

endmodule

[sv/cpp_dt_scale.sv]
// Two-stage product of a term and the step size, rounded half up to Q.28 or to half of that.
module cpp_dt_scale (
    input  logic                       i_clk,
    input  logic [1:0]                 i_en,
    input  logic                       i_half,
    input  logic [cpp_pkg::DTW-1:0]    i_dt,
    input  cpp_pkg::t_acc3             i_acc,
    output cpp_pkg::t_scl3             o_scl
);

    // The term is split at the binary point so that each multiplier stays narrow.
    logic        [56:0] r_lo [3];
    logic signed [38:0] r_hi [3];
    logic signed [67:0] w_sum [3];
    cpp_pkg::t_scl3     r_scl;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= 57'(i_acc[i][cpp_pkg::FRAC-1:0]) * 57'(i_dt);
                r_hi[i] <= 39'(signed'(i_acc[i][cpp_pkg::AW-1:cpp_pkg::FRAC]))
                         * 39'(signed'({1'b0, i_dt}));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = (68'(r_hi[i]) <<< cpp_pkg::FRAC) + 68'(signed'({1'b0, r_lo[i]}))
                     + (i_half ? (68'sd1 <<< cpp_pkg::FRAC) : (68'sd1 <<< (cpp_pkg::FRAC - 1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_scl[i] <= i_half ? w_sum[i][cpp_pkg::FRAC+cpp_pkg::SW:cpp_pkg::FRAC+1]
                                   : w_sum[i][cpp_pkg::FRAC+cpp_pkg::SW-1:cpp_pkg::FRAC];
            end
        end
    end

    assign o_scl = r_scl;

endmodule

[sv/charged_particle_push_unit.sv]
// Top level of the charged particle push: configuration, stage registers and output.
//
// Use: each word on the s_axis channel is one particle (velocity Q4.28, position Q20.28).
// The block returns one m_axis word per particle with the velocity and position after
// one time step in the field B, and a saturation flag in m_axis_tuser.
// B, the step size and the integrator mode are written over the cfg channel, which is
// always ready; write them only while no particle is in flight.
// m_axis_tvalid is the valid bit of the last stage. While the sink is ready, one particle
// is accepted in every cycle; the 13-stage pipeline (two cross products, two step
// scalings, velocity and position updates) is fully overlapped, so throughput is one word
// per cycle. Euler mode takes the same path and latency, it bypasses the midpoint cross
// product. Reset empties the pipeline and loads B = (0, 0, 1.0), step 0.01 and midpoint
// mode. When m_axis_tready is low the last stage holds its word; earlier stages keep
// accepting until every bubble is filled, then s_axis_tready falls. Nothing is lost.
module charged_particle_push_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // vel_x_in, vel_y_in, vel_z_in, pos_x_in, pos_y_in, pos_z_in
    input  logic [239:0]              s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // vel_x_out, vel_y_out, vel_z_out, pos_x_out, pos_y_out, pos_z_out
    output logic [239:0]              m_axis_tdata,
    // saturated
    output logic [0:0]                m_axis_tuser,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [cpp_pkg::IDXW-1:0]  i_cfg_index,
    input  logic [31:0]               i_cfg_data
);

    localparam int S_PROD1 = 0;
    localparam int S_ACC1  = 1;
    localparam int S_HMUL  = 2;
    localparam int S_HSUM  = 3;
    localparam int S_MID   = 4;
    localparam int S_PROD2 = 5;
    localparam int S_ACC2  = 6;
    localparam int S_FMUL  = 7;
    localparam int S_FSUM  = 8;
    localparam int S_VEL   = 9;
    localparam int S_PMUL  = 10;
    localparam int S_PRND  = 11;
    localparam int S_POS   = 12;

    typedef struct {
        cpp_pkg::t_vel3 v;
        cpp_pkg::t_pos3 r;
        cpp_pkg::t_acc3 p1;
        cpp_pkg::t_vel3 vc;
        cpp_pkg::t_vel3 vn;
        cpp_pkg::t_pos3 rn;
        logic           flag;
    } t_side;

    cpp_pkg::t_vel3              r_field;
    logic [cpp_pkg::DTW-1:0]     r_step;
    logic                        r_mode;

    cpp_pkg::t_pipe_ctrl         w_ctrl;
    t_side                       r_side [cpp_pkg::NS];
    t_side                       n_side [cpp_pkg::NS];

    cpp_pkg::t_acc3              w_acc1;
    cpp_pkg::t_acc3              w_acc2;
    cpp_pkg::t_acc3              w_sel;
    cpp_pkg::t_scl3              w_half;
    cpp_pkg::t_scl3              w_full;

    logic signed [61:0]          r_pm [3];
    logic signed [61:0]          w_prnd [3];
    logic signed [33:0]          r_pd [3];
    logic signed [cpp_pkg::VW+6:0] w_mid [3];
    logic signed [cpp_pkg::VW+6:0] w_vel [3];
    logic signed [cpp_pkg::PW:0]   w_pos [3];

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field[0] <= '0;
            r_field[1] <= '0;
            r_field[2] <= cpp_pkg::FIELD_Z_RESET;
            r_step     <= cpp_pkg::STEP_RESET;
            r_mode     <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cpp_pkg::CFG_FIELD_X: r_field[0] <= i_cfg_data;
                cpp_pkg::CFG_FIELD_Y: r_field[1] <= i_cfg_data;
                cpp_pkg::CFG_FIELD_Z: r_field[2] <= i_cfg_data;
                cpp_pkg::CFG_STEP:    r_step     <= i_cfg_data[cpp_pkg::DTW-1:0];
                cpp_pkg::CFG_MODE:    r_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cpp_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctrl      (w_ctrl)
    );

    assign s_axis_tready = w_ctrl.en[S_PROD1];
    assign m_axis_tvalid = w_ctrl.valid[S_POS];

    cpp_cross u_cross1 (
        .i_clk   (i_clk),
        .i_en    (w_ctrl.en[S_ACC1:S_PROD1]),
        .i_vel   (n_side[S_PROD1].v),
        .i_field (r_field),
        .o_acc   (w_acc1)
    );

    cpp_dt_scale u_half (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.en[S_HSUM:S_HMUL]),
        .i_half (1'b1),
        .i_dt   (r_step),
        .i_acc  (w_acc1),
        .o_scl  (w_half)
    );

    cpp_cross u_cross2 (
        .i_clk   (i_clk),
        .i_en    (w_ctrl.en[S_ACC2:S_PROD2]),
        .i_vel   (r_side[S_MID].vc),
        .i_field (r_field),
        .o_acc   (w_acc2)
    );

    // Euler mode steps with the first cross product, carried down the side lane.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sel[i] = r_mode ? w_acc2[i] : r_side[S_ACC2].p1[i];
        end
    end

    cpp_dt_scale u_full (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.en[S_FSUM:S_FMUL]),
        .i_half (1'b0),
        .i_dt   (r_step),
        .i_acc  (w_sel),
        .o_scl  (w_full)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mid[i]  = 39'(r_side[S_HSUM].v[i]) + 39'(w_half[i]);
            w_vel[i]  = 39'(r_side[S_FSUM].v[i]) + 39'(w_full[i]);
            w_prnd[i] = r_pm[i] + (62'sd1 <<< (cpp_pkg::FRAC - 1));
            w_pos[i]  = 49'(r_side[S_PRND].r[i]) + 49'(r_pd[i]);
        end
    end

    always_comb begin
        n_side[S_PROD1] = '{default: '0};
        for (int i = 0; i < 3; i++) begin
            n_side[S_PROD1].v[i] = s_axis_tdata[32*i +: 32];
            n_side[S_PROD1].r[i] = s_axis_tdata[96 + 48*i +: 48];
        end
        for (int k = 1; k < cpp_pkg::NS; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[S_HMUL].p1 = w_acc1;
        for (int i = 0; i < 3; i++) begin
            n_side[S_MID].vc[i] = cpp_pkg::sat_vel(w_mid[i]);
            n_side[S_VEL].vn[i] = cpp_pkg::sat_vel(w_vel[i]);
            n_side[S_POS].rn[i] = cpp_pkg::sat_pos(w_pos[i]);
        end
        // Clipping of the midpoint velocity counts only when it is used.
        n_side[S_MID].flag = r_side[S_HSUM].flag
                           | (r_mode & (cpp_pkg::vel_ovf(w_mid[0]) | cpp_pkg::vel_ovf(w_mid[1])
                                        | cpp_pkg::vel_ovf(w_mid[2])));
        n_side[S_VEL].flag = r_side[S_FSUM].flag | cpp_pkg::vel_ovf(w_vel[0])
                           | cpp_pkg::vel_ovf(w_vel[1]) | cpp_pkg::vel_ovf(w_vel[2]);
        n_side[S_POS].flag = r_side[S_PRND].flag | cpp_pkg::pos_ovf(w_pos[0])
                           | cpp_pkg::pos_ovf(w_pos[1]) | cpp_pkg::pos_ovf(w_pos[2]);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cpp_pkg::NS; k++) begin
            if (w_ctrl.en[k]) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    // Position step: new velocity times step, rounded, then added to the position.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.en[S_PMUL]) begin
            for (int i = 0; i < 3; i++) begin
                r_pm[i] <= 62'(r_side[S_VEL].vn[i]) * 62'(signed'({1'b0, r_step}));
            end
        end
        if (w_ctrl.en[S_PRND]) begin
            for (int i = 0; i < 3; i++) begin
                r_pd[i] <= w_prnd[i][61:cpp_pkg::FRAC];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_axis_tdata[32*i +: 32]      = r_side[S_POS].vn[i];
            m_axis_tdata[96 + 48*i +: 48] = r_side[S_POS].rn[i];
        end
    end

    assign m_axis_tuser[0] = r_side[S_POS].flag;

    // The output is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // An accepted word always lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> w_ctrl.valid[S_PROD1])
        else $error("accepted word missing from first stage");

    // While the sink stalls, input is taken only if some stage is empty.
    a_stall_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && s_axis_tready |-> w_ctrl.valid != '1)
        else $error("input accepted into a full stalled pipeline");

endmodule
